// File: hdl/ccse_pkg.sv
// Shared widths, beat types and pipeline depths for the contour cell segment extractor.
// No dependencies; every other file of the block imports it.
package ccse_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int EXT_W       = VALUE_WIDTH + 1;
    localparam int PROD_W      = 2 * EXT_W;
    localparam int DIV_STEPS   = 3;
    localparam int DIV_STAGES  = (EXT_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PIPE_STAGES = DIV_STAGES + 3;

    typedef logic signed [VALUE_WIDTH-1:0] t_val;
    typedef logic [1:0]                    t_tidx;

    typedef struct packed {
        t_val zbl;
        t_val zbr;
        t_val ztr;
        t_val ztl;
        t_val xl;
        t_val xr;
        t_val yb;
        t_val yt;
        t_val lvl;
        logic missing;
    } t_cell;

    typedef struct packed {
        logic [1:0][VALUE_WIDTH-1:0] px;
        logic [1:0][VALUE_WIDTH-1:0] py;
        logic [1:0][VALUE_WIDTH-1:0] pz;
        logic [1:0][VALUE_WIDTH-1:0] qx;
        logic [1:0][VALUE_WIDTH-1:0] qy;
        logic [1:0][VALUE_WIDTH-1:0] qz;
        t_val  lvl;
        t_tidx tidx;
        logic  last;
    } t_tri;

    typedef struct packed {
        logic [3:0][VALUE_WIDTH-1:0] base;
        logic [3:0][VALUE_WIDTH-1:0] mid;
        logic [3:0]                  neg;
        logic [1:0]                  dz0;
        t_val                        lvl;
        t_tidx                       tidx;
        logic                        last;
    } t_sb;

    typedef struct packed {
        t_val  sx;
        t_val  sy;
        t_val  ex;
        t_val  ey;
        t_val  lvl;
        t_tidx tidx;
        logic  last;
    } t_seg;

endpackage

// File: hdl/contour_cell_segment_extractor.sv
// Top level of the contour cell segment extractor: triangle issue front plus crossing pipeline.
// Depends on ccse_pkg, ccse_front, ccse_cross (and ccse_div below it).
//
// One input beat is one grid cell; each of its four triangles (bottom, right, top, left) that
// straddles the contour level yields one output beat, flagged last on the cell's final segment.
// The triangle issue stage sets the rate: it issues one straddling triangle per cycle while the
// downstream does not stall, retires a cell with none straddling without issuing, and drops a
// missing cell on arrival, so output beats can flow one per cycle when not stalled. From the
// accepted cell to the first segment the path runs through the cell and triangle registers,
// differences, products, eleven divider stages of three quotient bits each, and the output
// register. Backpressure collapses bubbles stage by stage.
module contour_cell_segment_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_z_bottom_left,
    input  logic [31:0] i_z_bottom_right,
    input  logic [31:0] i_z_top_left,
    input  logic [31:0] i_z_top_right,
    input  logic [31:0] i_x_left,
    input  logic [31:0] i_x_right,
    input  logic [31:0] i_y_bottom,
    input  logic [31:0] i_y_top,
    input  logic [31:0] i_contour_level,
    input  logic        i_corner_missing,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_start_x,
    output logic [31:0] o_start_y,
    output logic [31:0] o_end_x,
    output logic [31:0] o_end_y,
    output logic [31:0] o_segment_level,
    output logic [1:0]  o_triangle_index,
    output logic        o_last_segment
);
    import ccse_pkg::*;

    t_cell s_cell;
    t_tri  s_tri;
    t_seg  s_seg;
    logic  s_tri_valid, s_tri_stall;

    always_comb begin
        s_cell.zbl     = i_z_bottom_left;
        s_cell.zbr     = i_z_bottom_right;
        s_cell.ztr     = i_z_top_right;
        s_cell.ztl     = i_z_top_left;
        s_cell.xl      = i_x_left;
        s_cell.xr      = i_x_right;
        s_cell.yb      = i_y_bottom;
        s_cell.yt      = i_y_top;
        s_cell.lvl     = i_contour_level;
        s_cell.missing = i_corner_missing;
    end

    ccse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_cell  (s_cell),
        .o_valid (s_tri_valid),
        .i_stall (s_tri_stall),
        .o_tri   (s_tri)
    );

    ccse_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tri_valid),
        .o_stall (s_tri_stall),
        .i_tri   (s_tri),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_seg   (s_seg)
    );

    assign o_start_x        = s_seg.sx;
    assign o_start_y        = s_seg.sy;
    assign o_end_x          = s_seg.ex;
    assign o_end_y          = s_seg.ey;
    assign o_segment_level  = s_seg.lvl;
    assign o_triangle_index = s_seg.tidx;
    assign o_last_segment   = s_seg.last;

endmodule

// File: hdl/ccse_front.sv
// Cell register with centre point, and triangle issue: one straddling triangle per beat.
// Depends on ccse_pkg.
module ccse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ccse_pkg::t_cell i_cell,
    output logic           o_valid,
    input  logic           i_stall,
    output ccse_pkg::t_tri o_tri
);
    import ccse_pkg::*;

    localparam t_val TOP = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic  r_cv;
    t_cell r_cell;
    t_val  r_zc, r_xc, r_yc;
    logic [3:0] r_done;
    logic  r_tv;
    t_tri  r_tri;

    logic signed [VALUE_WIDTH+1:0] s_zsum;
    logic signed [VALUE_WIDTH:0]   s_xsum, s_ysum;
    t_val  cz [4];
    t_val  cx [4];
    t_val  cy [4];
    t_val  zn [4];
    logic [3:0] up;
    t_val  zn_c;
    logic  up_c;
    logic [3:0] straddle, pend, pick;
    t_tidx c0, c1;
    logic  last, e0, e1;
    logic  tri_rdy, issue, fin, cell_ld;
    t_val  vx [3];
    t_val  vy [3];
    t_val  vz [3];
    t_tri  n_tri;

    always_comb begin
        s_zsum = {{2{i_cell.zbl[VALUE_WIDTH-1]}}, i_cell.zbl}
               + {{2{i_cell.zbr[VALUE_WIDTH-1]}}, i_cell.zbr}
               + {{2{i_cell.ztr[VALUE_WIDTH-1]}}, i_cell.ztr}
               + {{2{i_cell.ztl[VALUE_WIDTH-1]}}, i_cell.ztl};
        s_xsum = {i_cell.xl[VALUE_WIDTH-1], i_cell.xl} + {i_cell.xr[VALUE_WIDTH-1], i_cell.xr};
        s_ysum = {i_cell.yb[VALUE_WIDTH-1], i_cell.yb} + {i_cell.yt[VALUE_WIDTH-1], i_cell.yt};
    end

    always_comb begin
        cz[0] = r_cell.zbl; cx[0] = r_cell.xl; cy[0] = r_cell.yb;
        cz[1] = r_cell.zbr; cx[1] = r_cell.xr; cy[1] = r_cell.yb;
        cz[2] = r_cell.ztr; cx[2] = r_cell.xr; cy[2] = r_cell.yt;
        cz[3] = r_cell.ztl; cx[3] = r_cell.xl; cy[3] = r_cell.yt;
        for (int k = 0; k < 4; k++) begin
            up[k] = (cz[k] > r_cell.lvl) || (cz[k] == r_cell.lvl && cz[k] != TOP);
            zn[k] = (cz[k] == r_cell.lvl && cz[k] != TOP) ? t_val'(cz[k] + 1) : cz[k];
        end
        up_c = (r_zc > r_cell.lvl) || (r_zc == r_cell.lvl && r_zc != TOP);
        zn_c = (r_zc == r_cell.lvl && r_zc != TOP) ? t_val'(r_zc + 1) : r_zc;
        for (int t = 0; t < 4; t++) begin
            straddle[t] = !((up[t] == up[(t+1)%4]) && (up[(t+1)%4] == up_c));
        end
        pend = straddle & ~r_done;
        pick = pend & (~pend + 4'd1);
        case (1'b1)
            pick[0]: c0 = 2'd0;
            pick[1]: c0 = 2'd1;
            pick[2]: c0 = 2'd2;
            default: c0 = 2'd3;
        endcase
        c1   = c0 + 2'd1;
        last = (pend & ~pick) == 4'd0;

        vx[0] = cx[c0]; vy[0] = cy[c0]; vz[0] = zn[c0];
        vx[1] = cx[c1]; vy[1] = cy[c1]; vz[1] = zn[c1];
        vx[2] = r_xc;   vy[2] = r_yc;   vz[2] = zn_c;
        e0 = up[c0] != up[c1];
        e1 = up[c1] != up_c;

        n_tri = '0;
        if (e0) begin
            n_tri.px[0] = vx[0]; n_tri.py[0] = vy[0]; n_tri.pz[0] = vz[0];
            n_tri.qx[0] = vx[1]; n_tri.qy[0] = vy[1]; n_tri.qz[0] = vz[1];
        end else begin
            n_tri.px[0] = vx[1]; n_tri.py[0] = vy[1]; n_tri.pz[0] = vz[1];
            n_tri.qx[0] = vx[2]; n_tri.qy[0] = vy[2]; n_tri.qz[0] = vz[2];
        end
        if (e0 && e1) begin
            n_tri.px[1] = vx[1]; n_tri.py[1] = vy[1]; n_tri.pz[1] = vz[1];
        end else begin
            n_tri.px[1] = vx[0]; n_tri.py[1] = vy[0]; n_tri.pz[1] = vz[0];
        end
        n_tri.qx[1] = vx[2]; n_tri.qy[1] = vy[2]; n_tri.qz[1] = vz[2];
        n_tri.lvl  = r_cell.lvl;
        n_tri.tidx = c0;
        n_tri.last = last;

        tri_rdy = !r_tv || !i_stall;
        issue   = r_cv && (pend != 4'd0) && tri_rdy;
        fin     = r_cv && ((pend == 4'd0) || (issue && last));
        cell_ld = !r_cv || fin;
    end

    assign o_stall = !cell_ld;
    assign o_valid = r_tv;
    assign o_tri   = r_tri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv   <= 1'b0;
            r_done <= 4'd0;
            r_tv   <= 1'b0;
        end else begin
            if (cell_ld) begin
                r_cv   <= i_valid && !i_cell.missing;
                r_done <= 4'd0;
            end else if (issue) begin
                r_done <= r_done | pick;
            end
            if (tri_rdy) begin
                r_tv <= issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_ld && i_valid) begin
            r_cell <= i_cell;
            r_zc   <= s_zsum[VALUE_WIDTH+1:2];
            r_xc   <= s_xsum[VALUE_WIDTH:1];
            r_yc   <= s_ysum[VALUE_WIDTH:1];
        end
        if (issue) begin
            r_tri <= n_tri;
        end
    end

    a_pick_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> $onehot(pick))
        else $error("issued triangle is not a single pending one");

    a_cell_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cv && !fin) |=> r_cv)
        else $error("cell dropped before all triangles issued");

    a_issue_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> r_tv)
        else $error("issued triangle beat lost");

endmodule

// File: hdl/ccse_div.sv
// Pipelined restoring divider, a few quotient bits per stage; quotient must fit EXT_W bits.
// Depends on ccse_pkg; stage enables come from the owning pipeline.
module ccse_div (
    input  logic                            i_clk,
    input  logic [ccse_pkg::DIV_STAGES-1:0] i_en,
    input  logic [ccse_pkg::PROD_W-1:0]     i_num,
    input  logic [ccse_pkg::EXT_W-1:0]      i_den,
    output logic [ccse_pkg::EXT_W-1:0]      o_quo
);
    import ccse_pkg::*;

    logic [EXT_W-1:0] r_rem [DIV_STAGES];
    logic [EXT_W-1:0] r_acc [DIV_STAGES];
    logic [EXT_W-1:0] r_den [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        logic [EXT_W-1:0] s_rem, s_acc, s_den, n_rem, n_acc;

        if (j == 0) begin : g_first
            assign s_rem = i_num[PROD_W-1:EXT_W];
            assign s_acc = i_num[EXT_W-1:0];
            assign s_den = i_den;
        end else begin : g_next
            assign s_rem = r_rem[j-1];
            assign s_acc = r_acc[j-1];
            assign s_den = r_den[j-1];
        end

        always_comb begin
            logic [EXT_W:0] t;
            logic           ge;
            n_rem = s_rem;
            n_acc = s_acc;
            for (int s = 0; s < DIV_STEPS; s++) begin
                if (j * DIV_STEPS + s < EXT_W) begin
                    t  = {n_rem, n_acc[EXT_W-1]};
                    ge = t >= {1'b0, s_den};
                    if (ge) begin
                        t = t - {1'b0, s_den};
                    end
                    n_rem = t[EXT_W-1:0];
                    n_acc = {n_acc[EXT_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem;
                r_acc[j] <= n_acc;
                r_den[j] <= s_den;
            end
        end
    end

    assign o_quo = r_acc[DIV_STAGES-1];

endmodule

// File: hdl/ccse_cross.sv
// Crossing pipeline: differences, 33x33 products, four pipelined divisions, final add.
// Depends on ccse_pkg and ccse_div.
module ccse_cross (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ccse_pkg::t_tri i_tri,
    output logic           o_valid,
    input  logic           i_stall,
    output ccse_pkg::t_seg o_seg
);
    import ccse_pkg::*;

    localparam int DIV0 = 2;
    localparam int LAST = PIPE_STAGES - 1;

    logic [PIPE_STAGES-1:0] r_v;
    logic [PIPE_STAGES-1:0] s_rdy;
    t_sb  r_sb [PIPE_STAGES-1];

    logic [EXT_W-1:0]  r_ua [2];
    logic [EXT_W-1:0]  r_ud [2];
    logic [EXT_W-1:0]  r_ub [4];
    logic [PROD_W-1:0] r_num [4];
    logic [EXT_W-1:0]  r_den [4];
    logic [EXT_W-1:0]  s_quo [4];
    t_seg r_seg;

    logic [EXT_W-1:0] n_ua [2];
    logic [EXT_W-1:0] n_ud [2];
    logic [EXT_W-1:0] n_ub [4];
    t_sb  n_sb;
    logic [VALUE_WIDTH-1:0] n_res [4];

    always_comb begin
        s_rdy[LAST] = !r_v[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            s_rdy[k] = !r_v[k] || s_rdy[k+1];
        end
    end

    assign o_stall = !s_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (s_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (s_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // differences and magnitudes
    always_comb begin
        logic signed [EXT_W-1:0] a, d, bx, by, sx, sy;
        n_sb = '0;
        for (int i = 0; i < 2; i++) begin
            a  = $signed({i_tri.lvl[VALUE_WIDTH-1], i_tri.lvl})
               - $signed({i_tri.pz[i][VALUE_WIDTH-1], i_tri.pz[i]});
            d  = $signed({i_tri.qz[i][VALUE_WIDTH-1], i_tri.qz[i]})
               - $signed({i_tri.pz[i][VALUE_WIDTH-1], i_tri.pz[i]});
            bx = $signed({i_tri.qx[i][VALUE_WIDTH-1], i_tri.qx[i]})
               - $signed({i_tri.px[i][VALUE_WIDTH-1], i_tri.px[i]});
            by = $signed({i_tri.qy[i][VALUE_WIDTH-1], i_tri.qy[i]})
               - $signed({i_tri.py[i][VALUE_WIDTH-1], i_tri.py[i]});
            sx = $signed({i_tri.qx[i][VALUE_WIDTH-1], i_tri.qx[i]})
               + $signed({i_tri.px[i][VALUE_WIDTH-1], i_tri.px[i]});
            sy = $signed({i_tri.qy[i][VALUE_WIDTH-1], i_tri.qy[i]})
               + $signed({i_tri.py[i][VALUE_WIDTH-1], i_tri.py[i]});
            n_ua[i]       = a[EXT_W-1] ? EXT_W'(-a) : EXT_W'(a);
            n_ud[i]       = d[EXT_W-1] ? EXT_W'(-d) : EXT_W'(d);
            n_ub[2*i]     = bx[EXT_W-1] ? EXT_W'(-bx) : EXT_W'(bx);
            n_ub[2*i+1]   = by[EXT_W-1] ? EXT_W'(-by) : EXT_W'(by);
            n_sb.neg[2*i]   = a[EXT_W-1] ^ bx[EXT_W-1] ^ d[EXT_W-1];
            n_sb.neg[2*i+1] = a[EXT_W-1] ^ by[EXT_W-1] ^ d[EXT_W-1];
            n_sb.dz0[i]     = d == '0;
            n_sb.base[2*i]   = i_tri.px[i];
            n_sb.base[2*i+1] = i_tri.py[i];
            n_sb.mid[2*i]    = sx[EXT_W-1:1];
            n_sb.mid[2*i+1]  = sy[EXT_W-1:1];
        end
        n_sb.lvl  = i_tri.lvl;
        n_sb.tidx = i_tri.tidx;
        n_sb.last = i_tri.last;
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[0]) begin
            r_ua     <= n_ua;
            r_ud     <= n_ud;
            r_ub     <= n_ub;
            r_sb[0]  <= n_sb;
        end
        if (s_rdy[1]) begin
            for (int k = 0; k < 4; k++) begin
                r_num[k] <= r_ua[k/2] * r_ub[k];
                r_den[k] <= r_ud[k/2];
            end
        end
        for (int k = 1; k < PIPE_STAGES - 1; k++) begin
            if (s_rdy[k]) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_div
        ccse_div u_div (
            .i_clk (i_clk),
            .i_en  (s_rdy[DIV0 +: DIV_STAGES]),
            .i_num (r_num[k]),
            .i_den (r_den[k]),
            .o_quo (s_quo[k])
        );
    end

    // signed quotient added to the start vertex; the edge midpoint instead where the edge is flat in z
    always_comb begin
        logic [EXT_W:0] sq, sum;
        for (int k = 0; k < 4; k++) begin
            sq  = r_sb[LAST-1].neg[k] ? -{1'b0, s_quo[k]} : {1'b0, s_quo[k]};
            sum = {{2{r_sb[LAST-1].base[k][VALUE_WIDTH-1]}}, r_sb[LAST-1].base[k]} + sq;
            n_res[k] = r_sb[LAST-1].dz0[k/2] ? r_sb[LAST-1].mid[k] : sum[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[LAST]) begin
            r_seg.sx   <= n_res[0];
            r_seg.sy   <= n_res[1];
            r_seg.ex   <= n_res[2];
            r_seg.ey   <= n_res[3];
            r_seg.lvl  <= r_sb[LAST-1].lvl;
            r_seg.tidx <= r_sb[LAST-1].tidx;
            r_seg.last <= r_sb[LAST-1].last;
        end
    end

    assign o_valid = r_v[LAST];
    assign o_seg   = r_seg;

endmodule
